// ----- sv/stfs_pkg.sv -----
// shared types and codes for the slot table with free stack
package stfs_pkg;

	localparam int IDX_BITS = 7;
	localparam int HANDLE_W = 32;

	typedef logic [1:0] kind_t;
	typedef logic [1:0] status_t;

	localparam kind_t OP_ALLOC   = 2'd0;
	localparam kind_t OP_PLACE   = 2'd1;
	localparam kind_t OP_LOOKUP  = 2'd2;
	localparam kind_t OP_RELEASE = 2'd3;

	localparam status_t ST_OK     = 2'd0;
	localparam status_t ST_REJECT = 2'd1;
	localparam status_t ST_FULL   = 2'd2;

	typedef struct packed {
		kind_t                kind;
		logic [IDX_BITS-1:0]  slot_index;
		logic [HANDLE_W-1:0]  handle;
	} req_word_t;

	typedef struct packed {
		logic [IDX_BITS-1:0]  result_index;
		logic [HANDLE_W-1:0]  result_handle;
		status_t              status;
	} rsp_word_t;

endpackage

// ----- sv/stfs_ram.sv -----
// generic single-write, single-read ram with registered read data
module stfs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- sv/stfs_slot.sv -----
// slot store: ram plus per-entry written flags so unwritten slots read as empty
module stfs_slot #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	output logic [WIDTH-1:0]         rd_data
);

	logic [DEPTH-1:0] vld_q;
	logic             rd_vld_q;
	logic [WIDTH-1:0] ram_data;

	stfs_ram #(
		.WIDTH (WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (ram_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? ram_data : '0;

endmodule

// ----- sv/slot_table_with_free_stack.sv -----
// slot table with lifo free stack: top level, control and write-back
// request and memory reads register at accept; the result registers at write-back
// a new request waits until the previous read-modify-write of the slot memory is done
// a new request is taken while the previous result still waits in the output register
// reset: counters and handshake clear at once; slots read empty through per-entry flags
// reset: no clearing sweep; free stack contents stay undefined and are tracked by a count
module slot_table_with_free_stack
	import stfs_pkg::*;
#(
	parameter int CAPACITY    = 128,
	parameter int HANDLE_BITS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  req_word_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_word_t rsp
);

	localparam int SLOT_DEPTH = (CAPACITY < 128) ? CAPACITY : 128;
	localparam int SA         = $clog2(SLOT_DEPTH);
	localparam int PW         = $clog2(CAPACITY);
	localparam int CW         = $clog2(CAPACITY + 1);
	localparam int STORE_BITS = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;

	logic                  busy_q;
	logic                  rsp_valid_q;
	rsp_word_t             rsp_q;
	logic [CW-1:0]         free_count_q;
	logic [CW-1:0]         next_unused_q;

	kind_t                 kind_s1;
	logic [IDX_BITS-1:0]   idx_s1;
	logic [STORE_BITS-1:0] handle_s1;

	logic                  accept;
	logic                  exec_fire;

	logic [STORE_BITS-1:0] slot_val;
	logic                  slot_we;
	logic [SA-1:0]         slot_wa;
	logic [STORE_BITS-1:0] slot_wd;
	logic [SA-1:0]         stk_rd;
	logic                  stk_we;
	logic [PW-1:0]         stk_wa;
	logic [CW-1:0]         free_count_d;
	logic [CW-1:0]         next_unused_d;
	logic [CW-1:0]         pick;
	logic                  got;
	logic                  in_range;
	rsp_word_t             rsp_d;

	assign req_ready = !busy_q;
	assign accept    = req_valid && req_ready;
	assign exec_fire = busy_q && (!rsp_valid_q || rsp_ready);

	stfs_slot #(
		.WIDTH (STORE_BITS),
		.DEPTH (SLOT_DEPTH)
	) u_slot (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (SA'(req.slot_index)),
		.wr_en   (slot_we),
		.wr_addr (slot_wa),
		.wr_data (slot_wd),
		.rd_data (slot_val)
	);

	stfs_ram #(
		.WIDTH (SA),
		.DEPTH (CAPACITY)
	) u_stack (
		.clk     (clk),
		.wr_en   (stk_we),
		.wr_addr (stk_wa),
		.wr_data (SA'(idx_s1)),
		.rd_en   (accept),
		.rd_addr (PW'(free_count_q - 1'b1)),
		.rd_data (stk_rd)
	);

	always_comb begin
		in_range      = 32'(idx_s1) < CAPACITY;
		slot_we       = 1'b0;
		slot_wa       = SA'(idx_s1);
		slot_wd       = handle_s1;
		stk_we        = 1'b0;
		stk_wa        = PW'(free_count_q);
		free_count_d  = free_count_q;
		next_unused_d = next_unused_q;
		pick          = '0;
		got           = 1'b0;
		rsp_d.result_index  = idx_s1;
		rsp_d.result_handle = '0;
		rsp_d.status        = ST_OK;
		unique case (kind_s1)
			OP_ALLOC: begin
				if (free_count_q != '0) begin
					pick         = CW'(stk_rd);
					free_count_d = free_count_q - 1'b1;
					got          = 1'b1;
				end else if (32'(next_unused_q) < CAPACITY) begin
					pick          = next_unused_q;
					next_unused_d = next_unused_q + 1'b1;
					got           = 1'b1;
				end
				if (got) begin
					// slots beyond the index range can never be read back
					slot_we            = 32'(pick) < SLOT_DEPTH;
					slot_wa            = SA'(pick);
					rsp_d.result_index = IDX_BITS'(pick);
				end else begin
					rsp_d.result_index = '0;
					rsp_d.status       = ST_FULL;
				end
			end
			OP_PLACE: begin
				if (!in_range || slot_val != '0) begin
					rsp_d.status = ST_REJECT;
				end else begin
					slot_we = 1'b1;
				end
			end
			OP_LOOKUP: begin
				if (in_range) begin
					rsp_d.result_handle = HANDLE_W'(slot_val);
				end
			end
			OP_RELEASE: begin
				if (!in_range || slot_val == '0) begin
					rsp_d.status = ST_REJECT;
				end else begin
					slot_we = 1'b1;
					slot_wd = '0;
					if (32'(free_count_q) < CAPACITY) begin
						stk_we       = 1'b1;
						free_count_d = free_count_q + 1'b1;
					end
				end
			end
		endcase
		slot_we = slot_we && exec_fire;
		stk_we  = stk_we && exec_fire;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1   <= req.kind;
			idx_s1    <= req.slot_index;
			handle_s1 <= STORE_BITS'(req.handle);
		end
		if (exec_fire) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= 1'b0;
			rsp_valid_q   <= 1'b0;
			free_count_q  <= '0;
			next_unused_q <= '0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (exec_fire) begin
				busy_q <= 1'b0;
			end
			if (exec_fire) begin
				rsp_valid_q   <= 1'b1;
				free_count_q  <= free_count_d;
				next_unused_q <= next_unused_d;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTH
	a_free_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(free_count_q) <= CAPACITY)
		else $error("free stack count above capacity");

	a_next_unused_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(next_unused_q) <= CAPACITY)
		else $error("bump pointer above capacity");

	a_rsp_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(busy_q))
		else $error("result word without a request in flight");

	a_count_moves_on_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(free_count_q != $past(free_count_q)) || (next_unused_q != $past(next_unused_q))
		|-> $past(exec_fire))
		else $error("stack count or bump pointer moved outside write-back");

	a_full_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		exec_fire && kind_s1 == OP_ALLOC && free_count_q == '0
		&& 32'(next_unused_q) >= CAPACITY |=> rsp.status == ST_FULL && rsp.result_index == '0)
		else $error("full allocate did not report full");
`endif

endmodule

// ----- sim/slot_table_with_free_stack_tb.sv -----
// testbench for the slot table with free stack: directed, fill, overflow, back-pressure and random operation runs
`timescale 1ns / 100ps

module slot_table_with_free_stack_tb;
	import stfs_pkg::*;

	localparam int TABLE_SIZE = 128;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	req_word_t req = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	rsp_word_t rsp;

	// shadow of the table state
	logic [HANDLE_W-1:0] slot_model [TABLE_SIZE];
	logic [IDX_BITS-1:0] freed_idx [TABLE_SIZE];
	int                  freed_count = 0;
	int                  bump_next = 0;

	rsp_word_t expected_rsp [$];
	int        errors = 0;
	bit        steady = 1'b0;
	int        hold_req = 0;
	int        hold_left = 0;

	slot_table_with_free_stack dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#10_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic rsp_word_t table_outcome(req_word_t w);
		rsp_word_t r;
		r.result_index  = w.slot_index;
		r.result_handle = '0;
		r.status        = ST_OK;
		case (w.kind)
			OP_ALLOC: begin
				if (freed_count > 0) begin
					freed_count--;
					r.result_index = freed_idx[freed_count];
					slot_model[r.result_index] = w.handle;
				end else if (bump_next < TABLE_SIZE) begin
					r.result_index = IDX_BITS'(bump_next);
					slot_model[bump_next] = w.handle;
					bump_next++;
				end else begin
					r.result_index = '0;
					r.status = ST_FULL;
				end
			end
			OP_PLACE: begin
				if (slot_model[w.slot_index] != '0)
					r.status = ST_REJECT;
				else
					slot_model[w.slot_index] = w.handle;
			end
			OP_LOOKUP: begin
				r.result_handle = slot_model[w.slot_index];
			end
			default: begin
				if (slot_model[w.slot_index] == '0) begin
					r.status = ST_REJECT;
				end else begin
					slot_model[w.slot_index] = '0;
					// push is dropped once the stack is full
					if (freed_count < TABLE_SIZE) begin
						freed_idx[freed_count] = w.slot_index;
						freed_count++;
					end
				end
			end
		endcase
		return r;
	endfunction

	function automatic logic [HANDLE_W-1:0] rand_handle();
		int roll;
		roll = $urandom_range(19);
		if (roll == 0)
			return '0;
		if (roll == 1)
			return '1;
		return HANDLE_W'($urandom);
	endfunction

	function automatic logic [IDX_BITS-1:0] pick_slot(bit occupied);
		int start;
		int i;
		start = $urandom_range(TABLE_SIZE - 1);
		for (int k = 0; k < TABLE_SIZE; k++) begin
			i = (start + k) % TABLE_SIZE;
			if ((slot_model[i] != '0) == occupied)
				return IDX_BITS'(i);
		end
		return IDX_BITS'(start);
	endfunction

	function automatic req_word_t random_word();
		req_word_t w;
		int roll;
		roll = $urandom_range(99);
		w.kind = roll < 30 ? OP_ALLOC : roll < 50 ? OP_PLACE : roll < 72 ? OP_LOOKUP : OP_RELEASE;
		w.slot_index = IDX_BITS'($urandom_range(TABLE_SIZE - 1));
		if ((w.kind == OP_PLACE || w.kind == OP_RELEASE) && $urandom_range(9) < 7)
			w.slot_index = pick_slot(w.kind == OP_RELEASE);
		w.handle = rand_handle();
		return w;
	endfunction

	// returns at the edge the word is taken, with valid still high
	task automatic send_word(req_word_t w);
		if (!steady) begin
			while ($urandom_range(99) < 26) begin
				req_valid <= 1'b0;
				@(posedge clk);
			end
		end
		expected_rsp.push_back(table_outcome(w));
		req       <= w;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
	endtask

	task automatic send_op(kind_t k, int idx, logic [HANDLE_W-1:0] h);
		req_word_t w;
		w.kind       = k;
		w.slot_index = IDX_BITS'(idx);
		w.handle     = h;
		send_word(w);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_rsp.size() != 0);
	endtask

	task automatic test_directed();
		send_op(OP_LOOKUP, 0, 32'hFFFF_FFFF);
		send_op(OP_LOOKUP, 127, 32'h0);
		send_op(OP_PLACE, 5, 32'h0);
		send_op(OP_LOOKUP, 5, 32'h0);
		send_op(OP_RELEASE, 5, 32'h0);
		send_op(OP_PLACE, 127, 32'hFFFF_FFFF);
		send_op(OP_PLACE, 127, 32'h0000_1234);
		send_op(OP_LOOKUP, 127, 32'h0);
		send_op(OP_ALLOC, 127, 32'hA5A5_A5A5);
		send_op(OP_ALLOC, 64, 32'h0);
		send_op(OP_LOOKUP, 1, 32'h0);
		send_op(OP_RELEASE, 1, 32'h0);
		send_op(OP_PLACE, 3, 32'h5A5A_5A5A);
		send_op(OP_RELEASE, 0, 32'h0);
		send_op(OP_ALLOC, 0, 32'hDEAD_BEEF);
		send_op(OP_RELEASE, 127, 32'h0);
		send_op(OP_PLACE, 127, 32'h0000_0001);
		// popped index already refilled by place gets overwritten
		send_op(OP_ALLOC, 85, 32'h8000_0000);
		send_op(OP_LOOKUP, 127, 32'h0);
		send_op(OP_ALLOC, 42, 32'h7FFF_FFFF);
		send_op(OP_ALLOC, 21, 32'h0F0F_0F0F);
		send_op(OP_LOOKUP, 3, 32'h0);
		send_op(OP_RELEASE, 3, 32'h0);
		send_op(OP_LOOKUP, 3, 32'h0);
	endtask

	task automatic test_fill();
		while (!(bump_next >= TABLE_SIZE && freed_count == 0))
			send_op(OP_ALLOC, $urandom_range(TABLE_SIZE - 1), rand_handle());
		repeat (3)
			send_op(OP_ALLOC, $urandom_range(TABLE_SIZE - 1), rand_handle());
		send_op(OP_LOOKUP, TABLE_SIZE - 1, 32'h0);
	endtask

	task automatic test_stack_overflow();
		for (int i = 0; i < TABLE_SIZE; i++)
			send_op(OP_RELEASE, i, rand_handle());
		while (freed_count < TABLE_SIZE) begin
			send_op(OP_PLACE, 9, HANDLE_W'($urandom) | 32'h1);
			send_op(OP_RELEASE, 9, 32'h0);
		end
		repeat (2) begin
			send_op(OP_PLACE, 9, HANDLE_W'($urandom) | 32'h1);
			send_op(OP_RELEASE, 9, 32'h0);
			send_op(OP_LOOKUP, 9, 32'h0);
		end
		while (freed_count > 0)
			send_op(OP_ALLOC, $urandom_range(TABLE_SIZE - 1), rand_handle());
		repeat (2)
			send_op(OP_ALLOC, $urandom_range(TABLE_SIZE - 1), rand_handle());
		send_op(OP_LOOKUP, 9, 32'h0);
	endtask

	task automatic test_backpressure();
		hold_req = 120;
		repeat (50)
			send_word(random_word());
	endtask

	task automatic test_random(int count);
		repeat (count)
			send_word(random_word());
	endtask

	task automatic test_steady(int count);
		steady = 1'b1;
		test_random(count);
		steady = 1'b0;
	endtask

	task automatic check_field(string name, logic [HANDLE_W-1:0] want, logic [HANDLE_W-1:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else if (hold_left > 0) begin
			rsp_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req > 0) begin
			rsp_ready <= 1'b0;
			hold_left <= hold_req;
			hold_req = 0;
		end else begin
			rsp_ready <= steady || ($urandom_range(99) >= 26);
		end
	end

	always @(posedge clk) begin
		rsp_word_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_rsp.size() == 0) begin
				errors++;
				$display("%0t: result word with none expected, actual %h", $time, rsp);
			end else begin
				want = expected_rsp.pop_front();
				check_field("result_index", HANDLE_W'(want.result_index),
					HANDLE_W'(rsp.result_index));
				check_field("result_handle", want.result_handle, rsp.result_handle);
				check_field("status", HANDLE_W'(want.status), HANDLE_W'(rsp.status));
			end
		end
	end

	initial begin
		for (int i = 0; i < TABLE_SIZE; i++) begin
			slot_model[i] = '0;
			freed_idx[i]  = '0;
		end
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		wait_drained();
		test_fill();
		wait_drained();
		test_stack_overflow();
		wait_drained();
		test_backpressure();
		wait_drained();
		test_random(600);
		test_steady(300);
		wait_drained();
		test_random(400);
		wait_drained();
		repeat (8)
			@(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
